// ----- rtl/tsse_pkg.sv -----
package tsse_pkg;

  // Field widths
  localparam int SAMPLE_W  = 15;
  localparam int STEP_W    = 8;
  localparam int SHOWN_W   = 16;
  localparam int BCD_W     = 16;
  localparam int SEG_W     = 8;
  localparam int P9_W      = 19;
  localparam int RECIP_W   = 20;
  localparam int PROD_W    = P9_W + RECIP_W;

  // One divider cell per quotient bit, one BCD cell per shown bit
  localparam int DIV_CELLS = SAMPLE_W;
  localparam int BCD_CELLS = SHOWN_W;

  localparam logic [STEP_W-1:0]  STEP_RESET = 8'd50;

  // floor(x/5) = (x * RECIP_FIVE) >> RECIP_SHIFT for x below 2^19
  localparam logic [RECIP_W-1:0] RECIP_FIVE  = 20'd838861;
  localparam int                 RECIP_SHIFT = 22;
  localparam logic [16:0]        F_OFFSET    = 17'd32;

  localparam logic [SEG_W-1:0] SEG_DEGREE = 8'h63;
  localparam logic [SEG_W-1:0] SEG_C      = 8'h39;
  localparam logic [SEG_W-1:0] SEG_F      = 8'h71;

  // Word moving through the divider chain
  typedef struct packed {
    logic                mode;
    logic [STEP_W-1:0]   rem;
    logic [SAMPLE_W-1:0] work;
  } div_word_t;

  // Word moving through the binary-to-BCD chain
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] celsius;
    logic [SHOWN_W-1:0]  bin;
    logic [BCD_W-1:0]    bcd;
  } bcd_word_t;

  // Finished result word
  typedef struct packed {
    logic [SAMPLE_W-1:0] celsius;
    logic [31:0]         right;
    logic [15:0]         left;
    logic                led;
  } out_word_t;

  // Seven-segment pattern of one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/tsse_div_cell.sv -----
module tsse_div_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [tsse_pkg::STEP_W-1:0]       divisor,
  input  logic                              in_valid,
  input  tsse_pkg::div_word_t               in_word,
  output logic                              out_valid,
  output tsse_pkg::div_word_t               out_word
);

  logic [tsse_pkg::STEP_W:0]   trial;
  logic [tsse_pkg::STEP_W:0]   diff;
  logic                        ge;
  tsse_pkg::div_word_t         word_next;

  // Restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {in_word.rem, in_word.work[tsse_pkg::SAMPLE_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    word_next.mode = in_word.mode;
    word_next.rem  = ge ? diff[tsse_pkg::STEP_W-1:0] : trial[tsse_pkg::STEP_W-1:0];
    word_next.work = {in_word.work[tsse_pkg::SAMPLE_W-2:0], ge};
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ----- rtl/tsse_bcd_cell.sv -----
module tsse_bcd_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tsse_pkg::bcd_word_t in_word,
  output logic                out_valid,
  output tsse_pkg::bcd_word_t out_word
);

  logic [tsse_pkg::BCD_W-1:0] adj;
  tsse_pkg::bcd_word_t        word_next;

  // Add three to every digit of five or more, then shift one bit in
  always_comb begin
    for (int d = 0; d < tsse_pkg::BCD_W / 4; d++) begin
      adj[d*4 +: 4] = (in_word.bcd[d*4 +: 4] >= 4'd5) ?
                      in_word.bcd[d*4 +: 4] + 4'd3 : in_word.bcd[d*4 +: 4];
    end
    word_next.mode    = in_word.mode;
    word_next.celsius = in_word.celsius;
    // drop the carry out of the thousands digit
    word_next.bcd     = {adj[tsse_pkg::BCD_W-2:0], in_word.bin[tsse_pkg::SHOWN_W-1]};
    word_next.bin     = {in_word.bin[tsse_pkg::SHOWN_W-2:0], 1'b0};
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ----- rtl/temperature_seven_segment_encoder.sv -----
// Temperature seven-segment encoder.
// Input channel: in_valid / in_stall carry one converter word (adc_word, bit 15
// ignored) and the unit switch celsius_mode. Output channel: out_valid /
// out_stall carry the Celsius value, the right display word (tens, ones,
// degree symbol, C or F glyph), the left display word (thousands, hundreds)
// and the Celsius LED bit.
// Configuration: a write on cfg_valid / cfg_ready sets the converter step
// (cfg_data); a step of zero divides by one. Write it only while idle.
// From acceptance to out_valid a word passes 1 input register,
// 15 divider cells (one quotient bit each), 2 Fahrenheit stages (times nine,
// then a reciprocal multiply by one fifth), 16 binary-to-BCD cells and the
// output register. One word is accepted every cycle while in_stall is low.
// When the receiver stalls, the output holds and a one-word skid register
// catches the next result; while the skid is full, in_stall is high and the
// whole chain holds. in_stall is a register, not a path from out_stall.
// Reset clears every valid bit, empties the output and the skid, and loads
// the step register with 50.
module temperature_seven_segment_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsse_pkg::STEP_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       adc_word,
  input  logic                              celsius_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tsse_pkg::SAMPLE_W-1:0]     temp_celsius,
  output logic [31:0]                       right_display,
  output logic [15:0]                       left_display,
  output logic                              celsius_led
);

  logic [tsse_pkg::STEP_W-1:0]  adc_step;
  logic [tsse_pkg::STEP_W-1:0]  divisor;
  logic                         en;

  logic                         div_v [0:tsse_pkg::DIV_CELLS];
  tsse_pkg::div_word_t          div_w [0:tsse_pkg::DIV_CELLS];

  logic                         f1_valid;
  logic                         f1_mode;
  logic [tsse_pkg::SAMPLE_W-1:0] f1_celsius;
  logic [tsse_pkg::P9_W-1:0]    f1_p9;

  logic                         f2_valid;
  logic                         f2_mode;
  logic [tsse_pkg::SAMPLE_W-1:0] f2_celsius;
  logic [tsse_pkg::PROD_W-1:0]  f2_prod;

  logic [tsse_pkg::SHOWN_W-1:0] shown;
  logic                         bcd_v [0:tsse_pkg::BCD_CELLS];
  tsse_pkg::bcd_word_t          bcd_w [0:tsse_pkg::BCD_CELLS];

  tsse_pkg::out_word_t          result;
  tsse_pkg::out_word_t          out_word;
  tsse_pkg::out_word_t          skid_word;
  logic                         skid_valid;
  logic                         pop;
  logic                         incoming;

  // Step register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_step <= tsse_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      adc_step <= cfg_data;
    end
  end

  assign divisor = (adc_step == '0) ? tsse_pkg::STEP_W'(1) : adc_step;

  // Chain advances unless the skid holds a word
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Input register: clear status bit, start remainder at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_w[0].mode <= celsius_mode;
      div_w[0].rem  <= '0;
      div_w[0].work <= adc_word[tsse_pkg::SAMPLE_W-1:0];
    end
  end

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < tsse_pkg::DIV_CELLS; k++) begin : g_div
    tsse_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .divisor   (divisor),
      .in_valid  (div_v[k]),
      .in_word   (div_w[k]),
      .out_valid (div_v[k+1]),
      .out_word  (div_w[k+1])
    );
  end

  // Fahrenheit: times nine, then divide by five through a reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= div_v[tsse_pkg::DIV_CELLS];
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_mode    <= div_w[tsse_pkg::DIV_CELLS].mode;
      f1_celsius <= div_w[tsse_pkg::DIV_CELLS].work;
      f1_p9      <= {4'b0, div_w[tsse_pkg::DIV_CELLS].work}
                  + {1'b0, div_w[tsse_pkg::DIV_CELLS].work, 3'b0};
      f2_mode    <= f1_mode;
      f2_celsius <= f1_celsius;
      f2_prod    <= tsse_pkg::PROD_W'(f1_p9) * tsse_pkg::PROD_W'(tsse_pkg::RECIP_FIVE);
    end
  end

  // Pick the shown value
  assign shown = f2_mode ? {1'b0, f2_celsius}
               : tsse_pkg::SHOWN_W'(f2_prod[tsse_pkg::PROD_W-1:tsse_pkg::RECIP_SHIFT]
                                    + tsse_pkg::F_OFFSET);

  assign bcd_v[0]         = f2_valid;
  assign bcd_w[0].mode    = f2_mode;
  assign bcd_w[0].celsius = f2_celsius;
  assign bcd_w[0].bin     = shown;
  assign bcd_w[0].bcd     = '0;

  // Binary-to-BCD chain, one shown bit per cell
  for (genvar k = 0; k < tsse_pkg::BCD_CELLS; k++) begin : g_bcd
    tsse_bcd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (bcd_v[k]),
      .in_word   (bcd_w[k]),
      .out_valid (bcd_v[k+1]),
      .out_word  (bcd_w[k+1])
    );
  end

  // Map digits to segments and pack the display words
  always_comb begin
    result.celsius = bcd_w[tsse_pkg::BCD_CELLS].celsius;
    result.led     = bcd_w[tsse_pkg::BCD_CELLS].mode;
    result.right   = {tsse_pkg::seg_of(bcd_w[tsse_pkg::BCD_CELLS].bcd[7:4]),
                      tsse_pkg::seg_of(bcd_w[tsse_pkg::BCD_CELLS].bcd[3:0]),
                      tsse_pkg::SEG_DEGREE,
                      bcd_w[tsse_pkg::BCD_CELLS].mode ? tsse_pkg::SEG_C : tsse_pkg::SEG_F};
    result.left    = {tsse_pkg::seg_of(bcd_w[tsse_pkg::BCD_CELLS].bcd[15:12]),
                      tsse_pkg::seg_of(bcd_w[tsse_pkg::BCD_CELLS].bcd[11:8])};
  end

  // Output register with one-word skid
  assign pop      = out_valid && !out_stall;
  assign incoming = bcd_v[tsse_pkg::BCD_CELLS] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else begin
      out_valid <= incoming || (out_valid && !pop);
      if (incoming && out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (incoming) begin
      if (!out_valid || pop) begin
        out_word <= result;
      end else begin
        skid_word <= result;
      end
    end
  end

  assign temp_celsius  = out_word.celsius;
  assign right_display = out_word.right;
  assign left_display  = out_word.left;
  assign celsius_led   = out_word.led;

endmodule

// ----- rtl/tsse_checker.sv -----
module tsse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] right_display,
  input logic        celsius_led
);

  // Glyph byte follows the unit LED
  a_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (celsius_led ? (right_display[7:0] == tsse_pkg::SEG_C)
                               : (right_display[7:0] == tsse_pkg::SEG_F)))
    else $error("unit glyph does not match celsius_led");

  // Degree symbol always in place
  a_degree: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_display[15:8] == tsse_pkg::SEG_DEGREE))
    else $error("degree symbol missing");

  // Nothing leaves the block right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(right_display)
                                  && $stable(celsius_led)))
    else $error("stalled output word changed");

endmodule

bind temperature_seven_segment_encoder tsse_checker u_tsse_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .right_display (right_display),
  .celsius_led   (celsius_led)
);
